// ===== src/streaming_descriptive_statistics_defines.svh =====
// ----------------------------------------------------------------------------
// Streaming descriptive statistics: assertion macros
// Checks compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef STREAMING_DESCRIPTIVE_STATISTICS_DEFINES_SVH
`define STREAMING_DESCRIPTIVE_STATISTICS_DEFINES_SVH
`ifndef SYNTH
`define SDS_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SDS_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define SDS_CHECK(lbl, prop, msg)
`define SDS_CHECK_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== src/sds_pkg.sv =====
// ----------------------------------------------------------------------------
// Streaming descriptive statistics package
// Beat types, engine command/result structs, sequencer states.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 17;
  localparam int POS_W    = 16;
  localparam int SUM_W    = 32;
  localparam int SQSUM_W  = 47;
  localparam int Q8_W     = 24;
  localparam int VAR_W    = 39;

  localparam int DEF_MAX_SAMPLES = 65536;

  // shared engine widths
  localparam int ENG_A_W = 72;  // dividend / quotient, radicand, multiplier
  localparam int ENG_B_W = 64;  // divisor, multiplicand, remainder, product
  localparam int ROOT_W  = 32;
  localparam int STEP_W  = 7;

  localparam logic [STEP_W-1:0] MUL_LAST  = STEP_W'(31);
  localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(ENG_A_W - 1);
  localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } sds_op_t;

  typedef enum logic [3:0] {
    S_ACC,
    S_LAUNCH,
    S_MEAN,
    S_RMS_DIV,
    S_RMS_SQRT,
    S_NQ,
    S_SS,
    S_DEN,
    S_VAR_DIV,
    S_DEV_SQRT,
    S_DONE
  } sds_state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       is_last;
  } sds_item_t;

  typedef struct packed {
    logic        [COUNT_W-1:0]  sample_total;
    logic signed [SUM_W-1:0]    set_sum;
    logic signed [SAMPLE_W-1:0] least_value;
    logic        [POS_W-1:0]    least_index;
    logic signed [SAMPLE_W-1:0] greatest_value;
    logic        [POS_W-1:0]    greatest_index;
    logic signed [Q8_W-1:0]     mean_q8;
    logic        [VAR_W-1:0]    variance_q8;
    logic        [Q8_W-1:0]     deviation_q8;
    logic        [Q8_W-1:0]     rms_q8;
    logic                       too_few_error;
  } sds_result_t;

  typedef struct packed {
    logic                 start;
    sds_op_t              op;
    logic [ENG_A_W-1:0]   a;
    logic [ENG_B_W-1:0]   b;
  } sds_cmd_t;

  typedef struct packed {
    logic                 done;
    logic [ENG_A_W-1:0]   quo;
    logic [ENG_B_W-1:0]   prod;
    logic [ROOT_W-1:0]    root;
  } sds_res_t;

endpackage

// ===== src/sds_engine.sv =====
// ----------------------------------------------------------------------------
// Shared iterative arithmetic engine
// One 64-bit add/subtract serves shift-add multiply, restoring divide and
// digit-by-digit square root, one step per cycle.
// ----------------------------------------------------------------------------
`include "streaming_descriptive_statistics_defines.svh"

module sds_engine (
  input  logic             clk,
  input  logic             rst,
  input  sds_pkg::sds_cmd_t cmd,
  output sds_pkg::sds_res_t res
);
  import sds_pkg::*;

  logic                busy;
  logic                done;
  logic [STEP_W-1:0]   cnt;
  sds_op_t             op;
  logic [ENG_A_W-1:0]  a_reg;
  logic [ENG_B_W-1:0]  b_reg;
  logic [ENG_B_W-1:0]  r_reg;
  logic [ROOT_W-1:0]   y_reg;

  logic [34:0]         rem_shift;
  logic [ENG_B_W-1:0]  alu_x;
  logic [ENG_B_W-1:0]  alu_y;
  logic                alu_sub;
  logic [ENG_B_W:0]    alu_sum;
  logic                ge;

  always_comb begin
    rem_shift = '0;
    alu_x     = '0;
    alu_y     = '0;
    alu_sub   = 1'b0;
    case (op)
      OP_MUL: begin
        alu_x = r_reg;
        alu_y = a_reg[0] ? b_reg : '0;
      end
      OP_DIV: begin
        rem_shift = {r_reg[33:0], a_reg[ENG_A_W-1]};
        alu_x     = ENG_B_W'(rem_shift);
        alu_y     = b_reg;
        alu_sub   = 1'b1;
      end
      OP_SQRT: begin
        rem_shift = {r_reg[32:0], a_reg[ENG_A_W-1 -: 2]};
        alu_x     = ENG_B_W'(rem_shift);
        alu_y     = ENG_B_W'({y_reg, 2'b01});
        alu_sub   = 1'b1;
      end
      default: ;
    endcase
    // carry out of x + ~y + 1 means x >= y
    alu_sum = {1'b0, alu_x} + {1'b0, (alu_sub ? ~alu_y : alu_y)} + (ENG_B_W+1)'(alu_sub);
    ge      = alu_sum[ENG_B_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
      op   <= OP_MUL;
    end else begin
      done <= busy && (cnt == '0);
      if (cmd.start) begin
        busy <= 1'b1;
        op   <= cmd.op;
        case (cmd.op)
          OP_MUL:  cnt <= MUL_LAST;
          OP_DIV:  cnt <= DIV_LAST;
          OP_SQRT: cnt <= SQRT_LAST;
          default: cnt <= MUL_LAST;
        endcase
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt - STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      a_reg <= (cmd.op == OP_SQRT) ? {cmd.a[ENG_B_W-1:0], 8'b0} : cmd.a;
      b_reg <= cmd.b;
      r_reg <= '0;
      y_reg <= '0;
    end else if (busy) begin
      case (op)
        OP_MUL: begin
          r_reg <= alu_sum[ENG_B_W-1:0];
          a_reg <= a_reg >> 1;
          b_reg <= b_reg << 1;
        end
        OP_DIV: begin
          r_reg <= ge ? alu_sum[ENG_B_W-1:0] : ENG_B_W'(rem_shift);
          a_reg <= {a_reg[ENG_A_W-2:0], ge};
        end
        OP_SQRT: begin
          r_reg <= ge ? alu_sum[ENG_B_W-1:0] : ENG_B_W'(rem_shift);
          y_reg <= {y_reg[ROOT_W-2:0], ge};
          a_reg <= a_reg << 2;
        end
        default: ;
      endcase
    end
  end

  assign res.done = done;
  assign res.quo  = a_reg;
  assign res.prod = r_reg;
  assign res.root = y_reg;

  `SDS_CHECK(a_start_idle, cmd.start |-> !busy, "engine started while busy")
  `SDS_CHECK_NEXT(a_last_step, busy && cnt == '0, done && !busy, "last step did not finish")
  `SDS_CHECK(a_done_idle, done |-> !busy, "done raised while busy")

endmodule

// ===== src/streaming_descriptive_statistics.sv =====
// A non-closing sample is registered into the accumulators; a set-closing sample gives
// its result once the engine passes finish (fewer when too few for unbiased variance).
// Throughput: 1 sample per cycle within a set; the closing step runs the shared
// engine for three 72-step divides and five 32-step multiply/root passes.
// Reset (rst, synchronous): clears accumulators, mode register and output valid.
// ----------------------------------------------------------------------------
// Streaming descriptive statistics
// Count, sum, extremes, mean, variance, deviation and RMS per sample set.
// ----------------------------------------------------------------------------
`include "streaming_descriptive_statistics_defines.svh"

module streaming_descriptive_statistics #(
  parameter int MAX_SAMPLES = sds_pkg::DEF_MAX_SAMPLES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  sds_pkg::sds_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output sds_pkg::sds_result_t result
);
  import sds_pkg::*;

  sds_state_t state, state_next;
  sds_cmd_t   cmd;
  sds_res_t   res;

  logic unbiased_mode;

  logic        [COUNT_W-1:0]  sample_counter;
  logic        [SUM_W-1:0]    running_sum;
  logic        [SQSUM_W-1:0]  running_square_sum;
  logic signed [SAMPLE_W-1:0] current_least;
  logic        [POS_W-1:0]    current_least_pos;
  logic signed [SAMPLE_W-1:0] current_greatest;
  logic        [POS_W-1:0]    current_greatest_pos;

  logic        [Q8_W-1:0]    mean_q;
  logic        [Q8_W-1:0]    rms_q;
  logic        [VAR_W-1:0]   var_q;
  logic        [Q8_W-1:0]    dev_q;
  logic        [ENG_B_W-1:0] nq;
  logic        [ENG_B_W-1:0] num;

  logic                       item_fire;
  logic                       room;
  logic                       first;
  logic signed [2*SAMPLE_W-1:0] sample_sq;
  logic        [SUM_W-1:0]    sum_mag;
  logic        [COUNT_W-1:0]  divisor_d;
  logic                       too_few;
  logic        [VAR_W-1:0]    var_sat;
  logic                       result_load;

  assign item_ready  = (state == S_ACC);
  assign item_fire   = item_valid && item_ready;
  assign room        = 32'(sample_counter) < 32'(MAX_SAMPLES);
  assign first       = (sample_counter == '0);
  assign sample_sq   = item.sample * item.sample;
  assign sum_mag     = running_sum[SUM_W-1] ? (SUM_W'(0) - running_sum) : running_sum;
  assign divisor_d   = unbiased_mode ? (sample_counter - COUNT_W'(1)) : sample_counter;
  assign too_few     = unbiased_mode && (sample_counter == COUNT_W'(1));
  assign var_sat     = (|res.quo[ENG_A_W-1:VAR_W]) ? '1 : res.quo[VAR_W-1:0];
  assign result_load = (state == S_DONE) && (!result_valid || result_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      unbiased_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      unbiased_mode <= cfg_wr_data;
    end
  end

  // per-beat accumulation
  always_ff @(posedge clk) begin
    if (rst || result_load) begin
      sample_counter       <= '0;
      running_sum          <= '0;
      running_square_sum   <= '0;
      current_least        <= '0;
      current_least_pos    <= '0;
      current_greatest     <= '0;
      current_greatest_pos <= '0;
    end else if (item_fire && room) begin
      if (first || item.sample < current_least) begin
        current_least     <= item.sample;
        current_least_pos <= sample_counter[POS_W-1:0];
      end
      if (first || item.sample > current_greatest) begin
        current_greatest     <= item.sample;
        current_greatest_pos <= sample_counter[POS_W-1:0];
      end
      running_sum <= running_sum + {{(SUM_W-SAMPLE_W){item.sample[SAMPLE_W-1]}}, item.sample};
      running_square_sum <= running_square_sum + SQSUM_W'($unsigned(sample_sq));
      sample_counter <= sample_counter + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_ACC: begin
        if (item_fire && item.is_last) state_next = S_LAUNCH;
      end
      S_LAUNCH: begin
        if (sample_counter == '0) begin
          state_next = S_DONE;
        end else begin
          cmd.start  = 1'b1;
          cmd.op     = OP_DIV;
          cmd.a      = ENG_A_W'({sum_mag, 8'b0});
          cmd.b      = ENG_B_W'(sample_counter);
          state_next = S_MEAN;
        end
      end
      S_MEAN: begin
        if (res.done) begin
          cmd.start  = 1'b1;
          cmd.op     = OP_DIV;
          cmd.a      = ENG_A_W'({running_square_sum, 16'b0});
          cmd.b      = ENG_B_W'(sample_counter);
          state_next = S_RMS_DIV;
        end
      end
      S_RMS_DIV: begin
        if (res.done) begin
          cmd.start  = 1'b1;
          cmd.op     = OP_SQRT;
          cmd.a      = ENG_A_W'(res.quo[ENG_B_W-1:0]);
          state_next = S_RMS_SQRT;
        end
      end
      S_RMS_SQRT: begin
        if (res.done) begin
          if (too_few) begin
            state_next = S_DONE;
          end else begin
            cmd.start  = 1'b1;
            cmd.op     = OP_MUL;
            cmd.a      = ENG_A_W'(sample_counter);
            cmd.b      = ENG_B_W'(running_square_sum);
            state_next = S_NQ;
          end
        end
      end
      S_NQ: begin
        if (res.done) begin
          cmd.start  = 1'b1;
          cmd.op     = OP_MUL;
          cmd.a      = ENG_A_W'(sum_mag);
          cmd.b      = ENG_B_W'(sum_mag);
          state_next = S_SS;
        end
      end
      S_SS: begin
        if (res.done) begin
          cmd.start  = 1'b1;
          cmd.op     = OP_MUL;
          cmd.a      = ENG_A_W'(divisor_d);
          cmd.b      = ENG_B_W'(sample_counter);
          state_next = S_DEN;
        end
      end
      S_DEN: begin
        if (res.done) begin
          cmd.start  = 1'b1;
          cmd.op     = OP_DIV;
          cmd.a      = {num, 8'b0};
          cmd.b      = ENG_B_W'(res.prod[33:0]);
          state_next = S_VAR_DIV;
        end
      end
      S_VAR_DIV: begin
        if (res.done) begin
          cmd.start  = 1'b1;
          cmd.op     = OP_SQRT;
          cmd.a      = ENG_A_W'({var_sat, 8'b0});
          state_next = S_DEV_SQRT;
        end
      end
      S_DEV_SQRT: begin
        if (res.done) state_next = S_DONE;
      end
      S_DONE: begin
        if (result_load) state_next = S_ACC;
      end
      default: state_next = S_ACC;
    endcase
  end

  // capture engine results as each pass finishes
  always_ff @(posedge clk) begin
    if (state == S_LAUNCH && sample_counter == '0) begin
      mean_q <= '0;
      rms_q  <= '0;
      var_q  <= '0;
      dev_q  <= '0;
    end
    if (res.done) begin
      case (state)
        S_MEAN: begin
          mean_q <= running_sum[SUM_W-1] ? (Q8_W'(0) - res.quo[Q8_W-1:0])
                                         : res.quo[Q8_W-1:0];
        end
        S_RMS_SQRT: begin
          rms_q <= (|res.root[ROOT_W-1:Q8_W]) ? '1 : res.root[Q8_W-1:0];
          if (too_few) begin
            var_q <= '0;
            dev_q <= '0;
          end
        end
        S_NQ: nq <= res.prod;
        // residual clamps at zero if the accumulators wrapped
        S_SS: num <= (nq > res.prod) ? (nq - res.prod) : '0;
        S_VAR_DIV: var_q <= var_sat;
        S_DEV_SQRT: dev_q <= res.root[Q8_W-1:0];
        default: ;
      endcase
    end
  end

  sds_engine u_engine (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.sample_total   <= sample_counter;
      result.set_sum        <= running_sum;
      result.least_value    <= current_least;
      result.least_index    <= current_least_pos;
      result.greatest_value <= current_greatest;
      result.greatest_index <= current_greatest_pos;
      result.mean_q8        <= mean_q;
      result.variance_q8    <= var_q;
      result.deviation_q8   <= dev_q;
      result.rms_q8         <= rms_q;
      result.too_few_error  <= too_few;
    end
  end

  `SDS_CHECK(a_few_zero, result_valid && result.too_few_error |-> result.variance_q8 == '0 && result.deviation_q8 == '0, "too-few result carries variance")
  `SDS_CHECK(a_order, result_valid |-> result.least_value <= result.greatest_value, "least above greatest")
  `SDS_CHECK(a_cnt_bound, 32'(sample_counter) <= 32'(MAX_SAMPLES), "sample count past limit")
  `SDS_CHECK_NEXT(a_finish_clear, result_load, sample_counter == '0 && result_valid, "set not cleared on finish")

endmodule

// ===== tb/streaming_descriptive_statistics_checker.sv =====
// ----------------------------------------------------------------------------
// Streaming descriptive statistics: scoreboard
// Tracks the mode register and every accepted sample beat and predicts the
// per-set summary. Each accepted result beat is compared field by field
// against the oldest outstanding summary.
// ----------------------------------------------------------------------------
module streaming_descriptive_statistics_checker #(
  parameter int MAX_SAMPLES = sds_pkg::DEF_MAX_SAMPLES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 item_valid,
  input  logic                 item_ready,
  input  sds_pkg::sds_item_t   item,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  sds_pkg::sds_result_t result,
  output int                   mismatch_count,
  output int                   summaries_owed
);
  import sds_pkg::*;

  localparam logic [63:0] VAR_CEIL = (64'd1 << VAR_W) - 64'd1;
  localparam logic [63:0] Q8_CEIL  = (64'd1 << Q8_W) - 64'd1;

  logic                       unbiased;
  logic [COUNT_W-1:0]         set_count;
  logic signed [SUM_W-1:0]    sum_acc;
  logic [SQSUM_W-1:0]         square_acc;
  logic signed [SAMPLE_W-1:0] least;
  logic signed [SAMPLE_W-1:0] greatest;
  logic [POS_W-1:0]           least_pos;
  logic [POS_W-1:0]           greatest_pos;

  sds_result_t summaries_due[$];
  sds_result_t want;
  int          errors = 0;

  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (64'd1 << i);
      if (trial * trial <= x) root = trial;
    end
    return root;
  endfunction

  function automatic logic [63:0] clamp(input logic [63:0] v, input logic [63:0] ceil);
    return (v > ceil) ? ceil : v;
  endfunction

  task automatic clear_set();
    set_count    = '0;
    sum_acc      = '0;
    square_acc   = '0;
    least        = '0;
    greatest     = '0;
    least_pos    = '0;
    greatest_pos = '0;
  endtask

  function automatic sds_result_t summarize_set();
    sds_result_t       r;
    logic signed [63:0] s;
    logic [63:0]       n, q, mag, mq, d, num, den, quo, rem, var_q8;
    r = '0;
    n = 64'(set_count);
    s = sum_acc;
    q = 64'(square_acc);
    mag = (s < 0) ? 64'(-s) : 64'(s);
    r.sample_total   = set_count;
    r.set_sum        = sum_acc;
    r.least_value    = least;
    r.least_index    = least_pos;
    r.greatest_value = greatest;
    r.greatest_index = greatest_pos;
    if (n != 0) begin
      mq = (mag * 64'd256) / n;
      r.mean_q8 = (s < 0) ? Q8_W'(64'd0 - mq) : Q8_W'(mq);
      r.rms_q8  = Q8_W'(clamp(root_floor((q << 16) / n), Q8_CEIL));
      d = unbiased ? n - 64'd1 : n;
      if (unbiased && n < 2) begin
        r.too_few_error = 1'b1;
      end else if (d != 0) begin
        // residual n*Q - S*S floors at zero
        num = (n * q > mag * mag) ? n * q - mag * mag : 64'd0;
        den = n * d;
        quo = num / den;
        rem = num % den;
        if (quo > (VAR_CEIL >> 8))
          var_q8 = VAR_CEIL;
        else
          var_q8 = clamp((quo << 8) + (rem * 64'd256) / den, VAR_CEIL);
        r.variance_q8  = VAR_W'(var_q8);
        r.deviation_q8 = Q8_W'(clamp(root_floor(var_q8 << 8), Q8_CEIL));
      end
    end
    return r;
  endfunction

  task automatic absorb_beat(input sds_item_t beat);
    longint sq;
    // beats past the sample limit leave the set untouched
    if (set_count < MAX_SAMPLES) begin
      if (set_count == 0 || beat.sample < least) begin
        least     = beat.sample;
        least_pos = POS_W'(set_count);
      end
      if (set_count == 0 || beat.sample > greatest) begin
        greatest     = beat.sample;
        greatest_pos = POS_W'(set_count);
      end
      sq         = longint'(beat.sample) * longint'(beat.sample);
      sum_acc    = sum_acc + beat.sample;
      square_acc = SQSUM_W'(64'(square_acc) + 64'(sq));
      set_count  = set_count + 1'b1;
    end
    if (beat.is_last) begin
      summaries_due.push_back(summarize_set());
      clear_set();
    end
  endtask

  task automatic note_field(input string field, input logic [63:0] want_v,
                            input logic [63:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, field, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      unbiased = 1'b0;
      clear_set();
      summaries_due.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (summaries_due.size() == 0) begin
          errors++;
          $display("%0t unexpected result beat: expected none, actual %0h", $time, result);
        end else begin
          want = summaries_due.pop_front();
          note_field("sample_total",   64'(want.sample_total),   64'(result.sample_total));
          note_field("set_sum",        64'(want.set_sum),        64'(result.set_sum));
          note_field("least_value",    64'(want.least_value),    64'(result.least_value));
          note_field("least_index",    64'(want.least_index),    64'(result.least_index));
          note_field("greatest_value", 64'(want.greatest_value), 64'(result.greatest_value));
          note_field("greatest_index", 64'(want.greatest_index), 64'(result.greatest_index));
          note_field("mean_q8",        64'(want.mean_q8),        64'(result.mean_q8));
          note_field("variance_q8",    64'(want.variance_q8),    64'(result.variance_q8));
          note_field("deviation_q8",   64'(want.deviation_q8),   64'(result.deviation_q8));
          note_field("rms_q8",         64'(want.rms_q8),         64'(result.rms_q8));
          note_field("too_few_error",  64'(want.too_few_error),  64'(result.too_few_error));
        end
      end
      if (cfg_wr_en) unbiased = cfg_wr_data;
      if (item_valid && item_ready) absorb_beat(item);
    end
    mismatch_count <= errors;
    summaries_owed <= summaries_due.size();
  end

endmodule

// ===== tb/streaming_descriptive_statistics_tb.sv =====
// ----------------------------------------------------------------------------
// Streaming descriptive statistics testbench
// Directed sets in both variance modes, then random sets under random
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module streaming_descriptive_statistics_tb;
  import sds_pkg::*;

  localparam int CYCLE_LIMIT    = 3_000_000;
  localparam int SETTLE_CYCLES  = 400;
  localparam int DIRECTED_LEN   = 22;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 235;

  typedef enum int {
    MIX_FULL,
    MIX_NARROW,
    MIX_EDGES,
    MIX_FLAT,
    MIX_HIGH
  } sample_mix_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cfg_wr_en   = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        item_valid  = 1'b0;
  sds_item_t   item        = '0;
  logic        result_ready = 1'b0;
  logic        item_ready;
  logic        result_valid;
  sds_result_t result;

  int mismatch_count;
  int summaries_owed;
  int cycle_count;
  int gap_pct  = 20;
  int hold_pct = 20;
  bit calm     = 1'b0;
  int sent;

  always #5 clk = ~clk;

  streaming_descriptive_statistics u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  streaming_descriptive_statistics_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result),
    .mismatch_count (mismatch_count),
    .summaries_owed (summaries_owed)
  );

  function automatic sds_item_t make_beat(input int v, input bit last);
    sds_item_t b;
    b.sample  = SAMPLE_W'(v);
    b.is_last = last;
    return b;
  endfunction

  // extremes, single-sample sets, flat set, ties, truncation of a negative mean
  function automatic sds_item_t directed_beat(input int k);
    case (k)
      0:  return make_beat(32767, 1);
      1:  return make_beat(-32768, 1);
      2:  return make_beat(0, 0);
      3:  return make_beat(0, 0);
      4:  return make_beat(0, 1);
      5:  return make_beat(5, 0);
      6:  return make_beat(-3, 0);
      7:  return make_beat(5, 0);
      8:  return make_beat(-3, 0);
      9:  return make_beat(7, 0);
      10: return make_beat(-3, 1);
      11: return make_beat(-32768, 0);
      12: return make_beat(32767, 0);
      13: return make_beat(-32768, 0);
      14: return make_beat(32767, 1);
      15: return make_beat(-1, 0);
      16: return make_beat(-1, 0);
      17: return make_beat(1, 1);
      18: return make_beat(3, 0);
      19: return make_beat(3, 1);
      20: return make_beat(-7, 0);
      default: return make_beat(2, 1);
    endcase
  endfunction

  function automatic logic [15:0] pick_sample(input sample_mix_t mix, input logic [15:0] base);
    case (mix)
      MIX_FULL:   return 16'($urandom);
      MIX_NARROW: return 16'($urandom_range(0, 16)) - 16'd8;
      MIX_EDGES: begin
        case ($urandom_range(0, 3))
          0:       return 16'h8000;
          1:       return 16'h7fff;
          2:       return 16'h8001;
          default: return 16'h7ffe;
        endcase
      end
      MIX_FLAT:   return ($urandom_range(0, 7) == 0) ? 16'($urandom) : base;
      default:    return 16'($urandom_range(20000, 32767));
    endcase
  endfunction

  task automatic send_beat(input sds_item_t b);
    if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= b;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
  endtask

  // sender holds off until every summary is back
  task automatic settle();
    item_valid <= 1'b0;
    @(posedge clk);
    while (summaries_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic run_directed();
    for (int k = 0; k < DIRECTED_LEN; k++) send_beat(directed_beat(k));
  endtask

  task automatic send_random_set(inout int count);
    int          len;
    int          roll;
    sample_mix_t mix;
    logic [15:0] base;
    roll = $urandom_range(0, 99);
    if (roll < 15)      len = 1;
    else if (roll < 30) len = 2;
    else if (roll < 80) len = $urandom_range(3, 16);
    else                len = $urandom_range(17, 120);
    mix  = sample_mix_t'($urandom_range(0, 4));
    base = 16'($urandom);
    for (int i = 0; i < len; i++) begin
      send_beat(make_beat(pick_sample(mix, base), i == len - 1));
      count++;
    end
  endtask

  // result side: random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && hold_pct != 0 && $urandom_range(1, 100) <= hold_pct) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      result_ready <= 1'b1;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("streaming_descriptive_statistics_tb: FAIL");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    run_directed();
    settle();
    write_mode(1'b1);
    run_directed();
    settle();
    write_mode(1'b0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      write_mode(ph[0]);
      case ($urandom_range(0, 3))
        0:       gap_pct = 0;
        1:       gap_pct = 5;
        2:       gap_pct = 15;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(0, 3))
        0:       hold_pct = 0;
        1:       hold_pct = 5;
        2:       hold_pct = 15;
        default: hold_pct = 35;
      endcase
      calm = (ph == RANDOM_PHASES - 1);
      sent = 0;
      while (sent < PHASE_ITEMS) send_random_set(sent);
    end

    settle();
    if (mismatch_count == 0 && summaries_owed == 0)
      $display("streaming_descriptive_statistics_tb: PASS");
    else
      $display("streaming_descriptive_statistics_tb: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/sds_pkg.sv
src/sds_engine.sv
src/streaming_descriptive_statistics.sv
tb/streaming_descriptive_statistics_checker.sv
tb/streaming_descriptive_statistics_tb.sv
